/* rtl/core/bfba_pkg.sv */
// shared types and constants for the best-fit block allocator
// used by bfba_ctrl, bfba_datapath and best_fit_block_allocator; no dependencies
`timescale 1ns / 1ps

package bfba_pkg;

   localparam int ACTION_W  = 1;
   localparam int INDEX_W   = 4;
   localparam int SIZE_W    = 16;
   localparam int COUNT_W   = 5;
   localparam int TDATA_W   = 24;

   localparam logic [ACTION_W-1:0] ACTION_LOAD    = 1'b0;
   localparam logic [ACTION_W-1:0] ACTION_REQUEST = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_we;   // write one block size, free the block
      logic start;     // latch request, clear best candidate, reset scan
      logic issue;     // read the table entry at the scan counter
      logic finish;    // register the result, mark the chosen block
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_done; // every block within the limit has been read
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

/* rtl/core/bfba_ctrl.sv */
// controller state machine of the best-fit block allocator
// depends on bfba_pkg for command, status and state types
`timescale 1ns / 1ps

module bfba_ctrl
   import bfba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ACTION_W-1:0] req_action,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  dp_status_type       status,
   output ctrl_cmd_type        cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_action == ACTION_REQUEST) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result registered while output still occupied");

   a_issue_not_done: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !status.scan_done)
      else $error("table read issued past the scan limit");
`endif

endmodule

/* rtl/core/bfba_datapath.sv */
// datapath of the best-fit block allocator: size memory, used marks, scan and result
// depends on bfba_pkg for field widths and command/status types
`timescale 1ns / 1ps

module bfba_datapath
   import bfba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  logic [INDEX_W-1:0] req_index,
   input  logic [SIZE_W-1:0]  req_size,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   output logic               rsp_granted,
   output logic [INDEX_W-1:0] rsp_block,
   output logic [SIZE_W-1:0]  rsp_leftover
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];

   logic [COUNT_W-1:0]    count_ff;
   logic [NUM_BLOCKS-1:0] used_ff, used_in;
   logic [SIZE_WIDTH-1:0] req_size_ff;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [SIZE_WIDTH-1:0] rd_size_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rd_used_ff;
   logic                  rd_valid_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [SIZE_WIDTH-1:0] best_size_ff;
   logic                  granted_ff;
   logic [INDEX_W-1:0]    block_ff;
   logic [SIZE_W-1:0]     leftover_ff;

   logic                  load_ok;
   logic [IDX_W-1:0]      load_addr;
   logic [IDX_W-1:0]      scan_addr;
   logic [SIZE_WIDTH-1:0] size_in;
   logic                  fit;
   logic                  better;
   logic [SIZE_WIDTH-1:0] left;

   assign load_ok   = (32'(req_index) < NUM_BLOCKS);
   assign load_addr = IDX_W'(req_index);
   assign scan_addr = cnt_ff[IDX_W-1:0];
   assign size_in   = SIZE_WIDTH'(req_size);

   // count above the table saturates
   assign limit_in = (32'(count_ff) >= NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(count_ff);

   assign status.scan_done = (cnt_ff == limit_ff);

   // candidates share one request size, so a smaller size is a smaller leftover
   assign fit    = rd_valid_ff && !rd_used_ff && (rd_size_ff >= req_size_ff);
   assign better = fit && (!found_ff || (rd_size_ff < best_size_ff));
   assign left   = best_size_ff - req_size_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_we && load_ok) begin
         size_mem[load_addr] <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_size_ff <= size_mem[scan_addr];
         rd_used_ff <= used_ff[scan_addr];
         rd_idx_ff  <= scan_addr;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.load_we && load_ok) begin
         used_in[load_addr] = 1'b0;
      end
      if (cmd.finish && found_ff) begin
         used_in[best_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         used_ff     <= '0;
         cnt_ff      <= '0;
         limit_ff    <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         used_ff     <= used_in;
         rd_valid_ff <= cmd.issue;
         if (cmd.start) begin
            cnt_ff   <= '0;
            limit_ff <= limit_in;
            found_ff <= 1'b0;
         end else if (cmd.finish) begin
            found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (better) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_size_ff <= size_in;
      end
      if (better) begin
         best_idx_ff  <= rd_idx_ff;
         best_size_ff <= rd_size_ff;
      end
      if (cmd.finish) begin
         granted_ff  <= found_ff;
         block_ff    <= found_ff ? INDEX_W'(best_idx_ff) : '0;
         leftover_ff <= found_ff ? SIZE_W'(left) : '0;
      end
   end

   assign rsp_granted  = granted_ff;
   assign rsp_block    = block_ff;
   assign rsp_leftover = leftover_ff;

`ifndef NO_ASSERTIONS
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (cnt_ff < limit_ff))
      else $error("scan counter beyond limit");

   a_best_is_free: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> !used_ff[best_idx_ff])
      else $error("best candidate is already in use");

   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_size_ff >= req_size_ff))
      else $error("best candidate smaller than request");
`endif

endmodule

/* rtl/core/best_fit_block_allocator.sv */
// a load item writes one block size and frees that block; a request item scans the table
// and its result is registered once the output is free, with no new item taken until then;
// the scan reads one block per cycle, limit = min(block_count, NUM_BLOCKS) blocks, through
// the single read port of the size memory; reset (synchronous, active high) frees all blocks
// and clears block_count; block sizes hold no reset value and are not cleared
`timescale 1ns / 1ps

module best_fit_block_allocator
   import bfba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_WIDTH = 16
)(
   input  logic               clock,
   input  logic               reset,
   // configuration: block_count
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   // input items
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // block_index[3:0], size_value[19:4], zero pad
   input  logic [ACTION_W-1:0] req_tuser,  // action[0]
   // result items
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // chosen_block[3:0], leftover[19:4], zero pad
   output logic               rsp_tuser    // granted[0]
);

   ctrl_cmd_type       cmd;
   dp_status_type      status;
   logic               rsp_granted;
   logic [INDEX_W-1:0] rsp_block;
   logic [SIZE_W-1:0]  rsp_leftover;

   // unpack input item fields
   logic [INDEX_W-1:0] req_index;
   logic [SIZE_W-1:0]  req_size;

   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_size  = req_tdata[INDEX_W +: SIZE_W];

   // sequencing: accept, scan, then register the result when the output is free
   bfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // size table, used marks, best-fit compare and result register
   bfba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_index    (req_index),
      .req_size     (req_size),
      .cmd          (cmd),
      .status       (status),
      .rsp_granted  (rsp_granted),
      .rsp_block    (rsp_block),
      .rsp_leftover (rsp_leftover)
   );

   // pack result item fields
   assign rsp_tdata = {{(TDATA_W - INDEX_W - SIZE_W){1'b0}}, rsp_leftover, rsp_block};
   assign rsp_tuser = rsp_granted;

endmodule
